/* rtl/core/kphe_pkg.sv */
package kphe_pkg;

  typedef enum logic [1:0] {
    PH_DOWN = 2'd0,
    PH_HOLD = 2'd1,
    PH_UP   = 2'd2
  } phase_e;

  typedef enum logic [7:0] {
    CFG_HOLD_THR = 8'd0,
    CFG_ECHO     = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] cnt;
  } entry_t;

  typedef struct packed {
    logic [7:0] key;
    phase_e     kind;
  } ev_t;

  localparam entry_t ENTRY_RESET = '{phase: PH_UP, cnt: 8'd0};

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [7:0] HOLD_THR_RESET = 8'd200;
  localparam logic [7:0] CMD_SEND_KEY   = 8'd35;
  localparam logic [7:0] SECOND_BASE    = 8'd64;
  localparam logic [7:0] THIRD_BASE     = 8'd128;

  localparam logic [2:0] LED_NONE = 3'd0;
  localparam logic [2:0] LED_DOWN = 3'd5;
  localparam logic [2:0] LED_HOLD = 3'd4;
  localparam logic [2:0] LED_UP   = 3'd7;

endpackage

/* rtl/core/kphe_fifo.sv */
module kphe_fifo
  import kphe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ev_t                push_data_i,
  input  logic               pop_i,
  output ev_t                pop_data_o,
  output logic               nonempty_o,
  output logic [FIFO_CW-1:0] cnt_o
);

  ev_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? FIFO_AW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? FIFO_AW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = FIFO_CW'(cnt_q + 1'b1);
    end else if (!push_i && pop_i) begin
      cnt_d = FIFO_CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign nonempty_o = (cnt_q != '0);
  assign cnt_o      = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != FIFO_CW'(FIFO_DEPTH)) || pop_i)
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("event queue underflow");
`endif

endmodule

/* rtl/core/kphe_front.sv */
module kphe_front
  import kphe_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         key_i,
  input  logic               raw_level_i,
  input  logic [7:0]         hold_thr_i,
  input  logic [FIFO_CW-1:0] fifo_cnt_i,
  output logic               push_o,
  output ev_t                push_data_o
);

  localparam int unsigned KeyAw = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  entry_t mem_q [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld_q;

  logic        take;
  logic        in_range;
  logic        s1_valid_q;
  logic [7:0]  s1_key_q;
  logic        s1_pressed_q;
  logic        fwd_q;
  entry_t      fwd_ent_q;
  entry_t      rd_q;
  logic        rdv_q;
  entry_t      cur;
  entry_t      nxt;
  logic [7:0]  cnt_inc;
  logic        ev_valid;
  phase_e      ev_kind;

  assign in_range   = {1'b0, key_i} < 9'(NUM_KEYS);
  assign in_ready_o = (4'(fifo_cnt_i) + 4'(s1_valid_q)) < 4'(FIFO_DEPTH);
  assign take       = in_valid_i && in_ready_o && in_range;

  always_comb begin
    cur      = fwd_q ? fwd_ent_q : (rdv_q ? rd_q : ENTRY_RESET);
    nxt      = cur;
    cnt_inc  = 8'(cur.cnt + 8'd1);
    ev_valid = 1'b0;
    ev_kind  = PH_UP;
    case (cur.phase)
      PH_DOWN: begin
        if (s1_pressed_q) begin
          nxt.cnt = cnt_inc;
          if (cnt_inc > hold_thr_i) begin
            nxt.phase = PH_HOLD;
            ev_valid  = 1'b1;
            ev_kind   = PH_HOLD;
          end
        end else begin
          nxt.phase = PH_UP;
          nxt.cnt   = 8'd0;
          ev_valid  = 1'b1;
          ev_kind   = PH_UP;
        end
      end
      PH_HOLD: begin
        if (!s1_pressed_q) begin
          nxt.phase = PH_UP;
          nxt.cnt   = 8'd0;
          ev_valid  = 1'b1;
          ev_kind   = PH_UP;
        end
      end
      default: begin
        if (s1_pressed_q) begin
          nxt.phase = PH_DOWN;
          ev_valid  = 1'b1;
          ev_kind   = PH_DOWN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      rdv_q      <= 1'b0;
      vld_q      <= '0;
    end else begin
      s1_valid_q <= take;
      fwd_q      <= take && s1_valid_q && (s1_key_q == key_i);
      if (take) begin
        rdv_q <= vld_q[key_i[KeyAw-1:0]];
      end
      if (s1_valid_q) begin
        vld_q[s1_key_q[KeyAw-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      mem_q[s1_key_q[KeyAw-1:0]] <= nxt;
    end
    if (take) begin
      rd_q         <= mem_q[key_i[KeyAw-1:0]];
      fwd_ent_q    <= nxt;
      s1_key_q     <= key_i;
      s1_pressed_q <= !raw_level_i;
    end
  end

  assign push_o           = s1_valid_q && ev_valid;
  assign push_data_o.key  = s1_key_q;
  assign push_data_o.kind = ev_kind;

`ifndef SYNTHESIS
  a_fwd_needs_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("bypass selected without an update in flight");

  a_room_for_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> fifo_cnt_i < FIFO_CW'(FIFO_DEPTH))
    else $error("update stage without queue room");
`endif

endmodule

/* rtl/core/kphe_back.sv */
module kphe_back
  import kphe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   echo_i,
  input  logic                   ev_valid_i,
  input  ev_t                    ev_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic       out_valid_q;
  logic [7:0] key_q;
  phase_e     kind_q;
  logic [7:0] second_q;
  logic [7:0] third_q;
  logic [2:0] led_q;
  logic [7:0] second_d;
  logic [7:0] third_d;
  logic [2:0] led_d;

  assign pop_o = ev_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    second_d = 8'(SECOND_BASE + {4'b0, ev_i.kind, 2'b0} + {6'b0, ev_i.key[7:6]});
    third_d  = 8'(THIRD_BASE + {2'b0, ev_i.key[5:0]});
    led_d    = LED_NONE;
    if (echo_i) begin
      case (ev_i.kind)
        PH_DOWN: led_d = LED_DOWN;
        PH_HOLD: led_d = LED_HOLD;
        PH_UP:   led_d = LED_UP;
        default: led_d = LED_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      key_q    <= ev_i.key;
      kind_q   <= ev_i.kind;
      second_q <= second_d;
      third_q  <= third_d;
      led_q    <= led_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b0, led_q, third_q, second_q, CMD_SEND_KEY, kind_q, key_q};

endmodule

/* rtl/core/key_press_hold_event_encoder.sv */
// Key press/hold event encoder. Feed one key sample per transaction (key index and
// active-low line level); each key moves through up, down and hold and every phase
// change comes out as one transaction carrying the key, the event kind, the three-byte
// send-key packet and, with LED echo on, an LED command. The block takes one sample
// every clock cycle while the event queue has room; once a sample is accepted, the
// registered read of the per-key state is updated and queued in the next cycle, and
// the event moves from the queue head into the output register when that is free.
// A four-entry event queue absorbs output stalls. Per-key valid flags give the
// reset state at once, so there is no clearing pass. Samples for keys at or above
// NUM_KEYS are taken and dropped. Write configuration only while the block is idle.
module key_press_hold_event_encoder
  import kphe_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] key_index, [8] raw_level
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] event_key, [9:8] event_kind, [17:10] command_byte, [25:18] second_byte,
  // [33:26] third_byte, [36:34] led_command
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [7:0]             cfg_index_i,
  input  logic [7:0]             cfg_data_i
);

  logic [7:0]         hold_thr_q;
  logic               echo_q;
  logic               push;
  ev_t                push_data;
  logic               pop;
  ev_t                pop_data;
  logic               fifo_nonempty;
  logic [FIFO_CW-1:0] fifo_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_thr_q <= HOLD_THR_RESET;
      echo_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HOLD_THR: hold_thr_q <= cfg_data_i;
        CFG_ECHO:     echo_q     <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  kphe_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .key_i       (s_axis_tdata[7:0]),
    .raw_level_i (s_axis_tdata[8]),
    .hold_thr_i  (hold_thr_q),
    .fifo_cnt_i  (fifo_cnt),
    .push_o      (push),
    .push_data_o (push_data)
  );

  kphe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .nonempty_o  (fifo_nonempty),
    .cnt_o       (fifo_cnt)
  );

  kphe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .echo_i      (echo_q),
    .ev_valid_i  (fifo_nonempty),
    .ev_i        (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* bench/tb.sv */
module tb;
  import kphe_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_SAMPLES  = 185;
  localparam logic [7:0]  CFG_SPARE_LOW  = 8'd2;
  localparam logic [7:0]  CFG_SPARE_HIGH = 8'd255;
  localparam int unsigned SEND_IDLE [3]  = '{26, 87, 0};
  localparam int unsigned RECV_IDLE [3]  = '{87, 26, 0};

  typedef struct {
    logic [7:0] key;
    phase_e     kind;
    logic [7:0] cmd;
    logic [7:0] second;
    logic [7:0] third;
    logic [2:0] led;
  } key_event_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [7:0]             cfg_index_i = '0;
  logic [7:0]             cfg_data_i = '0;

  phase_e      exp_phase [256];
  logic [7:0]  exp_count [256];
  logic [7:0]  cur_hold_thr = HOLD_THR_RESET;
  logic        cur_echo = 1'b0;
  key_event_t  pending_events [$];
  key_event_t  want;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = SEND_IDLE[0];
  int unsigned recv_idle_pct = RECV_IDLE[0];

  key_press_hold_event_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(string field, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v)
      flag_error($sformatf("%s mismatch: expected %0d, got %0d", field, want_v, got_v));
  endfunction

  function automatic void push_event(logic [7:0] key, phase_e kind);
    key_event_t ev;
    ev.key    = key;
    ev.kind   = kind;
    ev.cmd    = CMD_SEND_KEY;
    ev.second = SECOND_BASE + {4'd0, kind, 2'd0} + {6'd0, key[7:6]};
    ev.third  = THIRD_BASE + {2'd0, key[5:0]};
    if (!cur_echo) begin
      ev.led = LED_NONE;
    end else begin
      case (kind)
        PH_DOWN: ev.led = LED_DOWN;
        PH_HOLD: ev.led = LED_HOLD;
        default: ev.led = LED_UP;
      endcase
    end
    pending_events.push_back(ev);
  endfunction

  function automatic void predict_key_event(logic [7:0] key, logic raw);
    logic pressed;
    pressed = !raw;
    case (exp_phase[key])
      PH_DOWN: begin
        if (pressed) begin
          exp_count[key] = exp_count[key] + 8'd1;
          if (exp_count[key] > cur_hold_thr) begin
            exp_phase[key] = PH_HOLD;
            push_event(key, PH_HOLD);
          end
        end else begin
          exp_phase[key] = PH_UP;
          exp_count[key] = 8'd0;
          push_event(key, PH_UP);
        end
      end
      PH_HOLD: begin
        if (!pressed) begin
          exp_phase[key] = PH_UP;
          exp_count[key] = 8'd0;
          push_event(key, PH_UP);
        end
      end
      default: begin
        if (pressed) begin
          exp_phase[key] = PH_DOWN;
          push_event(key, PH_DOWN);
        end
      end
    endcase
  endfunction

  task automatic send_sample(logic [7:0] key, logic raw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-9){1'b0}}, raw, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_key_event(key, raw);
  endtask

  task automatic wait_for_events();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HOLD_THR) cur_hold_thr = data;
    else if (idx == CFG_ECHO) cur_echo = data[0];
  endtask

  task automatic set_config(logic [7:0] thr, logic echo);
    write_reg(CFG_HOLD_THR, thr);
    write_reg(CFG_ECHO, {7'd0, echo});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_config();
    send_sample(8'd0, 1'b0);
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b1);
    send_sample(8'd128, 1'b1);
    send_sample(8'd64, 1'b0);
    send_sample(8'd64, 1'b1);
    send_sample(8'd63, 1'b0);
    send_sample(8'd63, 1'b1);
    wait_for_events();
  endtask

  task automatic test_threshold_zero();
    set_config(8'd0, 1'b1);
    send_sample(8'hAA, 1'b0);
    send_sample(8'hAA, 1'b0);
    send_sample(8'hAA, 1'b0);
    send_sample(8'hAA, 1'b1);
    send_sample(8'hAA, 1'b1);
    send_sample(8'h55, 1'b0);
    send_sample(8'h55, 1'b0);
    send_sample(8'h55, 1'b1);
    wait_for_events();
  endtask

  task automatic test_threshold_top();
    set_config(8'd254, 1'b0);
    repeat (257) send_sample(8'd1, 1'b0);
    send_sample(8'd1, 1'b1);
    wait_for_events();
    // counter wraps and never passes the threshold
    set_config(8'd255, 1'b1);
    repeat (300) send_sample(8'd2, 1'b0);
    send_sample(8'd2, 1'b1);
    wait_for_events();
  endtask

  task automatic test_spare_index();
    write_reg(CFG_SPARE_LOW, 8'd0);
    write_reg(CFG_SPARE_HIGH, 8'd0);
    cfg_valid_i <= 1'b0;
    repeat (5) send_sample(8'd3, 1'b0);
    send_sample(8'd3, 1'b1);
    wait_for_events();
  endtask

  task automatic test_random_traffic();
    logic [7:0]  pool [6];
    logic [7:0]  key;
    int unsigned sent;
    int unsigned run;
    int unsigned rel;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = SEND_IDLE[mode];
      recv_idle_pct = RECV_IDLE[mode];
      for (int sub = 0; sub < 2; sub++) begin
        set_config((sub == 0) ? 8'($urandom_range(6)) : 8'($urandom_range(40)),
                   1'($urandom_range(1)));
        foreach (pool[i]) pool[i] = 8'($urandom_range(255));
        sent = 0;
        while (sent < PHASE_SAMPLES) begin
          if ($urandom_range(99) < 85) begin
            key = pool[$urandom_range(5)];
            run = $urandom_range(cur_hold_thr + 3, 1);
            rel = $urandom_range(2, 1);
            repeat (run) send_sample(key, 1'b0);
            repeat (rel) send_sample(key, 1'b1);
            sent += run + rel;
          end else begin
            send_sample(8'($urandom_range(255)), 1'($urandom_range(1)));
            sent++;
          end
        end
        wait_for_events();
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          flag_error($sformatf("unexpected event: key %0d kind %0d",
                               m_axis_tdata[7:0], m_axis_tdata[9:8]));
        end else begin
          want = pending_events.pop_front();
          check_field("event_key", want.key, m_axis_tdata[7:0]);
          check_field("event_kind", want.kind, m_axis_tdata[9:8]);
          check_field("command_byte", want.cmd, m_axis_tdata[17:10]);
          check_field("second_byte", want.second, m_axis_tdata[25:18]);
          check_field("third_byte", want.third, m_axis_tdata[33:26]);
          check_field("led_command", want.led, m_axis_tdata[36:34]);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[key_press_hold_event_encoder] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    foreach (exp_phase[i]) begin
      exp_phase[i] = PH_UP;
      exp_count[i] = 8'd0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_config();
    test_threshold_zero();
    test_threshold_top();
    test_spare_index();
    test_random_traffic();
    if (pending_events.size() != 0)
      flag_error($sformatf("%0d events never arrived", pending_events.size()));
    if (error_count == 0) begin
      $display("[key_press_hold_event_encoder] OK");
    end else begin
      $display("[key_press_hold_event_encoder] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/kphe_pkg.sv
rtl/core/kphe_fifo.sv
rtl/core/kphe_front.sv
rtl/core/kphe_back.sv
rtl/core/key_press_hold_event_encoder.sv
bench/tb.sv
